[sv/rilbp_pkg.sv]
// Shared types and constants for the rotation-invariant LBP block.
// No dependencies; every other file refers to this package by scoped name.
package rilbp_pkg;

   localparam int unsigned MAX_WIDTH_DEFAULT  = 1024;
   localparam int unsigned PIXEL_BITS_DEFAULT = 8;

   localparam int unsigned IN_PIXEL_BITS  = 8;
   localparam int unsigned CODE_BITS      = 8;
   localparam int unsigned CFG_WIDTH_BITS  = 11;
   localparam int unsigned CFG_HEIGHT_BITS = 16;
   localparam int unsigned COL_FIELD_BITS  = 13;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_LEVEL_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 32;

   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;

   localparam logic [CFG_WIDTH_BITS-1:0]  WIDTH_RESET  = CFG_WIDTH_BITS'(64);
   localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = CFG_HEIGHT_BITS'(64);

   typedef struct packed {
      logic                       restart;
      logic [COL_FIELD_BITS-1:0]  last_col;
      logic [CFG_HEIGHT_BITS-1:0] last_row;
   } frame_cfg_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] pattern;
      logic                 row_end;
      logic                 frame_end;
   } lbp_item_type;

endpackage

[sv/rilbp_channels.sv]
// Valid/ready channel interfaces for the pixel input and the code output.
// Depends on rilbp_pkg for field widths.
interface rilbp_req_if;
   logic                                valid;
   logic                                ready;
   logic [rilbp_pkg::IN_PIXEL_BITS-1:0] pixel;
   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface rilbp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rilbp_pkg::CODE_BITS-1:0] lbp_code;
   logic                            row_end;
   logic                            frame_end;
   modport source (output valid, output lbp_code, output row_end, output frame_end,
                   input ready);
   modport sink   (input valid, input lbp_code, input row_end, input frame_end,
                   output ready);
endinterface

[sv/rilbp_csr.sv]
// APB-style register block: image width and height, clamped frame limits.
// Depends on rilbp_pkg.
module rilbp_csr #(
   parameter int unsigned MAX_WIDTH = rilbp_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rilbp_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [rilbp_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [rilbp_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                pready,
   output rilbp_pkg::frame_cfg_type            frame_cfg
);

   localparam int unsigned EW = rilbp_pkg::COL_FIELD_BITS + 1;

   logic [rilbp_pkg::CFG_WIDTH_BITS-1:0]  width_ff, width_in;
   logic [rilbp_pkg::CFG_HEIGHT_BITS-1:0] height_ff, height_in;
   logic                                  wr_en;
   logic                                  reg_idx;
   logic [EW-1:0]                         width_ext;
   logic [EW-1:0]                         width_max;
   logic [EW-1:0]                         last_col;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[2];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         unique case (reg_idx)
            rilbp_pkg::CSR_IDX_WIDTH:  width_in  = pwdata[rilbp_pkg::CFG_WIDTH_BITS-1:0];
            rilbp_pkg::CSR_IDX_HEIGHT: height_in = pwdata[rilbp_pkg::CFG_HEIGHT_BITS-1:0];
            default:                   width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rilbp_pkg::WIDTH_RESET;
         height_ff <= rilbp_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         rilbp_pkg::CSR_IDX_WIDTH:  prdata = rilbp_pkg::CSR_DATA_BITS'(width_ff);
         rilbp_pkg::CSR_IDX_HEIGHT: prdata = rilbp_pkg::CSR_DATA_BITS'(height_ff);
         default:                   prdata = '0;
      endcase
   end

   // clamp width to 3..MAX_WIDTH and height to at least 3
   assign width_ext = EW'(width_ff);
   assign width_max = EW'(MAX_WIDTH);

   always_comb begin
      priority if (width_ext < EW'(3)) begin
         last_col = EW'(2);
      end else if (width_ext > width_max) begin
         last_col = width_max - EW'(1);
      end else begin
         last_col = width_ext - EW'(1);
      end
   end

   always_comb begin
      frame_cfg.restart  = wr_en;
      frame_cfg.last_col = last_col[rilbp_pkg::COL_FIELD_BITS-1:0];
      if (height_ff < rilbp_pkg::CFG_HEIGHT_BITS'(3)) begin
         frame_cfg.last_row = rilbp_pkg::CFG_HEIGHT_BITS'(2);
      end else begin
         frame_cfg.last_row = height_ff - rilbp_pkg::CFG_HEIGHT_BITS'(1);
      end
   end

endmodule

[sv/rilbp_front.sv]
// Front end: pixel intake, raster position, line store, 3x3 window and
// neighbour comparison byte. Depends on rilbp_pkg and rilbp_channels.
module rilbp_front #(
   parameter int unsigned MAX_WIDTH  = rilbp_pkg::MAX_WIDTH_DEFAULT,
   parameter int unsigned PIXEL_BITS = rilbp_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   rilbp_req_if.sink                              req,
   input  rilbp_pkg::frame_cfg_type               frame_cfg,
   input  logic [rilbp_pkg::QUEUE_LEVEL_BITS-1:0] queue_level,
   output logic                                   push,
   output rilbp_pkg::lbp_item_type                push_item
);

   localparam int unsigned CB = $clog2(MAX_WIDTH);
   localparam int unsigned LB = rilbp_pkg::QUEUE_LEVEL_BITS + 1;

   logic [CB-1:0]                          col_ff, col_in;
   logic [rilbp_pkg::CFG_HEIGHT_BITS-1:0]  row_ff, row_in;
   logic                                   s1_valid_ff;
   logic [CB-1:0]                          s1_addr_ff;
   logic [PIXEL_BITS-1:0]                  s1_pixel_ff;
   logic                                   s1_emit_ff;
   logic                                   s1_row_end_ff;
   logic                                   s1_frame_end_ff;
   logic [2*PIXEL_BITS-1:0]                line_mem [MAX_WIDTH];
   logic [2*PIXEL_BITS-1:0]                line_rd_ff;
   logic [PIXEL_BITS-1:0]                  prev_ff [3];
   logic [PIXEL_BITS-1:0]                  cur_ff [3];
   logic [PIXEL_BITS-1:0]                  up_px;
   logic [PIXEL_BITS-1:0]                  mid_px;
   logic [PIXEL_BITS-1:0]                  centre;
   logic [CB-1:0]                          last_col;
   logic                                   accept;
   logic                                   at_last_col;
   logic                                   at_last_row;

   assign req.ready = (LB'(queue_level) + LB'(s1_valid_ff)) < LB'(rilbp_pkg::QUEUE_DEPTH);
   assign accept    = req.valid & req.ready;

   assign last_col    = frame_cfg.last_col[CB-1:0];
   assign at_last_col = (col_ff == last_col);
   assign at_last_row = (row_ff == frame_cfg.last_row);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (frame_cfg.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (at_last_col) begin
            col_in = '0;
            row_in = at_last_row ? '0 : row_ff + rilbp_pkg::CFG_HEIGHT_BITS'(1);
         end else begin
            col_in = col_ff + CB'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff      <= col_ff;
         s1_pixel_ff     <= PIXEL_BITS'(req.pixel);
         s1_emit_ff      <= (row_ff >= rilbp_pkg::CFG_HEIGHT_BITS'(2)) && (col_ff >= CB'(2));
         s1_row_end_ff   <= at_last_col;
         s1_frame_end_ff <= at_last_col & at_last_row;
      end
   end

   // line store entry: upper row in the high half, middle row in the low half
   always_ff @(posedge clock) begin
      if (accept) begin
         line_rd_ff <= line_mem[col_ff];
      end
      if (s1_valid_ff) begin
         line_mem[s1_addr_ff] <= {line_rd_ff[PIXEL_BITS-1:0], s1_pixel_ff};
      end
   end

   assign up_px  = line_rd_ff[2*PIXEL_BITS-1:PIXEL_BITS];
   assign mid_px = line_rd_ff[PIXEL_BITS-1:0];
   assign centre = cur_ff[1];

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         prev_ff[0] <= cur_ff[0];
         prev_ff[1] <= cur_ff[1];
         prev_ff[2] <= cur_ff[2];
         cur_ff[0]  <= up_px;
         cur_ff[1]  <= mid_px;
         cur_ff[2]  <= s1_pixel_ff;
      end
   end

   // clockwise from top-left, top-left in the most significant bit
   always_comb begin
      push                = s1_valid_ff & s1_emit_ff;
      push_item.pattern   = {prev_ff[0] >= centre, cur_ff[0] >= centre, up_px >= centre,
                             mid_px >= centre, s1_pixel_ff >= centre, cur_ff[2] >= centre,
                             prev_ff[2] >= centre, prev_ff[1] >= centre};
      push_item.row_end   = s1_row_end_ff;
      push_item.frame_end = s1_frame_end_ff;
   end

endmodule

[sv/rilbp_queue.sv]
// Short queue between front and back ends, held in flip-flops.
// Depends on rilbp_pkg.
module rilbp_queue (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push,
   input  rilbp_pkg::lbp_item_type                push_item,
   input  logic                                   pop,
   output logic                                   not_empty,
   output rilbp_pkg::lbp_item_type                head_item,
   output logic [rilbp_pkg::QUEUE_LEVEL_BITS-1:0] level
);

   localparam int unsigned PB = $clog2(rilbp_pkg::QUEUE_DEPTH);

   rilbp_pkg::lbp_item_type                entry_ff [rilbp_pkg::QUEUE_DEPTH];
   logic [PB-1:0]                          wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]                          rd_ptr_ff, rd_ptr_in;
   logic [rilbp_pkg::QUEUE_LEVEL_BITS-1:0] level_ff, level_in;

   assign level     = level_ff;
   assign not_empty = (level_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PB'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PB'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   level_in = level_ff + rilbp_pkg::QUEUE_LEVEL_BITS'(1);
         2'b01:   level_in = level_ff - rilbp_pkg::QUEUE_LEVEL_BITS'(1);
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[sv/rilbp_back.sv]
// Back end: minimum over the eight circular rotations, output register.
// Depends on rilbp_pkg and rilbp_channels.
module rilbp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    not_empty,
   input  rilbp_pkg::lbp_item_type head_item,
   output logic                    pop,
   rilbp_rsp_if.source             rsp
);

   localparam int unsigned CW = rilbp_pkg::CODE_BITS;

   logic [CW-1:0] rot [8];
   logic [CW-1:0] min_a [4];
   logic [CW-1:0] min_b [2];
   logic [CW-1:0] min_code;
   logic          valid_ff, valid_in;
   logic [CW-1:0] code_ff;
   logic          row_end_ff;
   logic          frame_end_ff;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         rot[i] = CW'((head_item.pattern << i) | (head_item.pattern >> (CW - i)));
      end
      for (int i = 0; i < 4; i++) begin
         min_a[i] = (rot[2*i] < rot[2*i+1]) ? rot[2*i] : rot[2*i+1];
      end
      for (int i = 0; i < 2; i++) begin
         min_b[i] = (min_a[2*i] < min_a[2*i+1]) ? min_a[2*i] : min_a[2*i+1];
      end
      min_code = (min_b[0] < min_b[1]) ? min_b[0] : min_b[1];
   end

   assign pop      = not_empty & (~valid_ff | rsp.ready);
   assign valid_in = pop | (valid_ff & ~rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         code_ff      <= min_code;
         row_end_ff   <= head_item.row_end;
         frame_end_ff <= head_item.frame_end;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.lbp_code  = code_ff;
   assign rsp.row_end   = row_end_ff;
   assign rsp.frame_end = frame_end_ff;

endmodule

[sv/rotation_invariant_lbp_3x3.sv]
// Top level of the rotation-invariant 3x3 LBP block.
// Depends on rilbp_pkg, rilbp_channels, rilbp_csr, rilbp_front, rilbp_queue, rilbp_back.
//
// Usage:
//   req carries grey pixels in raster order, one per transfer (valid/ready).
//   rsp carries one LBP code per interior pixel, with row_end on the last
//   interior pixel of a row and frame_end on the last one of the frame.
//   Border pixels produce no transfer on rsp.
//   The APB-style port holds image_width at address 0 and image_height at 4;
//   any write restarts the frame position. Write only while the block is idle.
//   A code passes the window and comparison stage, the queue and the output
//   register in that order before it transfers on rsp.
//   Throughput: one pixel per cycle while req.ready is high, set by the
//   single-port-read line store.
//   Reset clears position, queue and output valid, and sets width and height
//   to 64; line store contents are not cleared and need no clearing pass.
//   When rsp stalls, the output register holds and the queue fills; req.ready
//   drops once the queue has no room for the pixels already in flight.
module rotation_invariant_lbp_3x3 #(
   parameter int unsigned MAX_WIDTH  = rilbp_pkg::MAX_WIDTH_DEFAULT,
   parameter int unsigned PIXEL_BITS = rilbp_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   rilbp_req_if.sink                           req,
   rilbp_rsp_if.source                         rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rilbp_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [rilbp_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [rilbp_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                pready
);

   rilbp_pkg::frame_cfg_type               frame_cfg;
   logic                                   push;
   rilbp_pkg::lbp_item_type                push_item;
   logic                                   pop;
   logic                                   not_empty;
   rilbp_pkg::lbp_item_type                head_item;
   logic [rilbp_pkg::QUEUE_LEVEL_BITS-1:0] queue_level;

   rilbp_csr #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .frame_cfg (frame_cfg)
   );

   rilbp_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .frame_cfg   (frame_cfg),
      .queue_level (queue_level),
      .push        (push),
      .push_item   (push_item)
   );

   rilbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .not_empty (not_empty),
      .head_item (head_item),
      .level     (queue_level)
   );

   rilbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head_item (head_item),
      .pop       (pop),
      .rsp       (rsp)
   );

endmodule

[tb/rotation_invariant_lbp_3x3_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for rotation_invariant_lbp_3x3: streams pixel frames of many sizes
// and compares every LBP code, row_end and frame_end with a predictor held here.
// Depends on rilbp_pkg, rilbp_channels and the block's RTL.
module rotation_invariant_lbp_3x3_tb;

   localparam int unsigned LINE_DEPTH    = rilbp_pkg::MAX_WIDTH_DEFAULT;
   localparam int unsigned LINE_IDX_BITS = $clog2(LINE_DEPTH);
   localparam int unsigned STALL_LIMIT   = 4000;
   localparam int unsigned DRAIN_CYCLES  = 8;
   localparam int unsigned ITEMS_PER_MODE = 155;

   typedef enum logic [1:0] {STEP_PIXEL, STEP_WIDTH, STEP_HEIGHT} step_kind_type;

   typedef struct packed {
      step_kind_type           kind;
      logic [15:0]             value;
      logic                    typed;
      rilbp_pkg::lbp_item_type result;
   } stim_row_type;

   localparam rilbp_pkg::lbp_item_type NO_CODE = '0;

   localparam stim_row_type DIRECTED_ROWS [0:30] = '{
      '{STEP_WIDTH,  16'd3,   1'b0, NO_CODE},
      '{STEP_HEIGHT, 16'd3,   1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd255, 1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd255, 1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd255, 1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd255, 1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd255, 1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd255, 1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd255, 1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd255, 1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd255, 1'b1, '{8'hFF, 1'b1, 1'b1}},
      '{STEP_PIXEL,  16'd0,   1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd0,   1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd0,   1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd0,   1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd255, 1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd0,   1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd0,   1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd0,   1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd0,   1'b1, '{8'h00, 1'b1, 1'b1}},
      '{STEP_WIDTH,  16'd0,   1'b0, NO_CODE},
      '{STEP_HEIGHT, 16'd0,   1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd200, 1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd0,   1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd0,   1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd0,   1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd128, 1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd0,   1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd0,   1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd0,   1'b0, NO_CODE},
      '{STEP_PIXEL,  16'd0,   1'b1, '{8'h01, 1'b1, 1'b1}}
   };

   logic                                clock;
   logic                                reset;
   logic                                psel;
   logic                                penable;
   logic                                pwrite;
   logic [rilbp_pkg::CSR_ADDR_BITS-1:0] paddr;
   logic [rilbp_pkg::CSR_DATA_BITS-1:0] pwdata;
   logic [rilbp_pkg::CSR_DATA_BITS-1:0] prdata;
   logic                                pready;

   rilbp_req_if req_bus ();
   rilbp_rsp_if rsp_bus ();

   rotation_invariant_lbp_3x3 u_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // predictor state
   logic [rilbp_pkg::CFG_WIDTH_BITS-1:0]  cfg_width  = rilbp_pkg::WIDTH_RESET;
   logic [rilbp_pkg::CFG_HEIGHT_BITS-1:0] cfg_height = rilbp_pkg::HEIGHT_RESET;
   logic [7:0]                 upper_store  [LINE_DEPTH];
   logic [7:0]                 middle_store [LINE_DEPTH];
   logic [7:0]                 pixel_window [9];
   int unsigned                col_pos = 0;
   int unsigned                row_pos = 0;

   rilbp_pkg::lbp_item_type expected_codes [$];
   rilbp_pkg::lbp_item_type oldest_code;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned mismatch_count = 0;
   int unsigned pixels_sent    = 0;
   int unsigned codes_checked  = 0;
   int unsigned frames_seen    = 0;
   int unsigned register_writes = 0;

   function automatic int unsigned effective_width();
      if (cfg_width < 3) return 3;
      if (cfg_width > LINE_DEPTH) return LINE_DEPTH;
      return 32'(cfg_width);
   endfunction

   function automatic int unsigned effective_height();
      return (cfg_height < 3) ? 3 : 32'(cfg_height);
   endfunction

   function automatic logic [7:0] min_rotation(input logic [7:0] pattern);
      logic [7:0] best;
      logic [7:0] turned;
      best = pattern;
      turned = pattern;
      for (int i = 1; i < 8; i++) begin
         turned = {turned[6:0], turned[7]};
         if (turned < best) best = turned;
      end
      return best;
   endfunction

   function automatic void predict_pixel(input logic [7:0] value, output logic has_code,
                                         output rilbp_pkg::lbp_item_type code);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      logic [7:0]  centre;
      logic [7:0]  pattern;
      w = effective_width();
      h = effective_height();
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= h) ? h - 1 : row_pos;
      pixel_window[0] = pixel_window[1];
      pixel_window[1] = pixel_window[2];
      pixel_window[3] = pixel_window[4];
      pixel_window[4] = pixel_window[5];
      pixel_window[6] = pixel_window[7];
      pixel_window[7] = pixel_window[8];
      pixel_window[2] = upper_store[c[LINE_IDX_BITS-1:0]];
      pixel_window[5] = middle_store[c[LINE_IDX_BITS-1:0]];
      pixel_window[8] = value;
      upper_store[c[LINE_IDX_BITS-1:0]]  = middle_store[c[LINE_IDX_BITS-1:0]];
      middle_store[c[LINE_IDX_BITS-1:0]] = value;
      centre  = pixel_window[4];
      pattern = {pixel_window[0] >= centre, pixel_window[1] >= centre,
                 pixel_window[2] >= centre, pixel_window[5] >= centre,
                 pixel_window[8] >= centre, pixel_window[7] >= centre,
                 pixel_window[6] >= centre, pixel_window[3] >= centre};
      has_code       = (r >= 2) && (c >= 2);
      code.pattern   = min_rotation(pattern);
      code.row_end   = (c == w - 1);
      code.frame_end = (c == w - 1) && (r == h - 1);
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endfunction

   function automatic logic [7:0] random_pixel();
      case ($urandom_range(0, 2))
         0: return 8'($urandom_range(0, 255));
         1: return 8'($urandom_range(0, 3) * 85);
         default: return 8'($urandom_range(127, 129));
      endcase
   endfunction

   task automatic csr_cycle(input logic is_write, input logic idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      @(negedge clock);
   endtask

   task automatic check_register(input logic idx, input logic [31:0] want);
      logic [31:0] readback;
      logic [31:0] field_mask;
      field_mask = (idx == rilbp_pkg::CSR_IDX_WIDTH) ? (32'd1 << rilbp_pkg::CFG_WIDTH_BITS) - 1
                                                     : (32'd1 << rilbp_pkg::CFG_HEIGHT_BITS) - 1;
      csr_cycle(1'b0, idx, '0, readback);
      if ((readback & field_mask) != (want & field_mask)) begin
         $display("%0t register %0d readback: expected %h actual %h", $time, idx,
                  want & field_mask, readback & field_mask);
         mismatch_count++;
      end
   endtask

   task automatic write_register(input logic idx, input logic [31:0] value);
      logic [31:0] unused;
      csr_cycle(1'b1, idx, value, unused);
      if (idx == rilbp_pkg::CSR_IDX_WIDTH) cfg_width = value[rilbp_pkg::CFG_WIDTH_BITS-1:0];
      else cfg_height = value[rilbp_pkg::CFG_HEIGHT_BITS-1:0];
      col_pos = 0;
      row_pos = 0;
      register_writes++;
      check_register(idx, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // drop valid, wait for outstanding codes, then let the pipeline empty
   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      while (expected_codes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic send_pixel(input logic [7:0] value, input logic typed,
                             input rilbp_pkg::lbp_item_type typed_code);
      logic                    has_code;
      rilbp_pkg::lbp_item_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_pixel(value, has_code, predicted);
      if (has_code) expected_codes.push_back(typed ? typed_code : predicted);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic send_random_pixels(input int unsigned count);
      for (int unsigned n = 0; n < count; n++) send_pixel(random_pixel(), 1'b0, NO_CODE);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_codes.size() == 0) begin
            $display("%0t unexpected code: expected none actual %h/%b/%b", $time,
                     rsp_bus.lbp_code, rsp_bus.row_end, rsp_bus.frame_end);
            mismatch_count++;
         end else begin
            oldest_code = expected_codes.pop_front();
            codes_checked++;
            if (rsp_bus.frame_end) frames_seen++;
            if (rsp_bus.lbp_code !== oldest_code.pattern) begin
               $display("%0t lbp_code: expected %h actual %h", $time, oldest_code.pattern,
                        rsp_bus.lbp_code);
               mismatch_count++;
            end
            if (rsp_bus.row_end !== oldest_code.row_end) begin
               $display("%0t row_end: expected %b actual %b", $time, oldest_code.row_end,
                        rsp_bus.row_end);
               mismatch_count++;
            end
            if (rsp_bus.frame_end !== oldest_code.frame_end) begin
               $display("%0t frame_end: expected %b actual %b", $time, oldest_code.frame_end,
                        rsp_bus.frame_end);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (psel && penable && pready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      int unsigned phase_items;
      int unsigned frame_pixels;
      int unsigned burst;
      logic [31:0] new_width;
      logic [31:0] new_height;

      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.pixel = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      check_register(rilbp_pkg::CSR_IDX_WIDTH, 32'(rilbp_pkg::WIDTH_RESET));
      check_register(rilbp_pkg::CSR_IDX_HEIGHT, 32'(rilbp_pkg::HEIGHT_RESET));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);

      send_idle_pct  = 10;
      recv_stall_pct = 82;
      for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
         case (DIRECTED_ROWS[i].kind)
            STEP_WIDTH: begin
               wait_until_drained();
               write_register(rilbp_pkg::CSR_IDX_WIDTH, 32'(DIRECTED_ROWS[i].value));
            end
            STEP_HEIGHT: begin
               wait_until_drained();
               write_register(rilbp_pkg::CSR_IDX_HEIGHT, 32'(DIRECTED_ROWS[i].value));
            end
            default: begin
               send_pixel(DIRECTED_ROWS[i].value[7:0], DIRECTED_ROWS[i].typed,
                          DIRECTED_ROWS[i].result);
            end
         endcase
      end

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct  = 10;
               recv_stall_pct = 82;
            end
            1: begin
               send_idle_pct  = 82;
               recv_stall_pct = 10;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         phase_items = 0;
         while (phase_items < ITEMS_PER_MODE) begin
            wait_until_drained();
            new_width  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                                     : $urandom_range(3, 12);
            new_height = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                                     : $urandom_range(3, 7);
            if ($urandom_range(0, 3) != 0) write_register(rilbp_pkg::CSR_IDX_WIDTH, new_width);
            write_register(rilbp_pkg::CSR_IDX_HEIGHT, new_height);
            frame_pixels = effective_width() * effective_height();
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2 * frame_pixels)
                                                : frame_pixels * $urandom_range(1, 2);
            send_random_pixels(burst);
            phase_items += burst;
         end
         if (mode == 0) begin
            // widest line and tallest frame: only the first row fills, so no codes
            wait_until_drained();
            write_register(rilbp_pkg::CSR_IDX_WIDTH, 32'(LINE_DEPTH));
            write_register(rilbp_pkg::CSR_IDX_HEIGHT, 32'hFFFF);
            send_random_pixels(40);
            // oversized width clamps to the line depth: a short burst on the first row
            wait_until_drained();
            write_register(rilbp_pkg::CSR_IDX_WIDTH, 32'h7FF);
            write_register(rilbp_pkg::CSR_IDX_HEIGHT, 32'd3);
            send_random_pixels(40);
         end
      end

      req_bus.valid <= 1'b0;
      while (expected_codes.size() != 0) @(negedge clock);
      repeat (4 * DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d pixels, %0d codes checked, %0d frame ends", pixels_sent,
               codes_checked, frames_seen);
      $display("%0d register writes across clamped, minimum and maximum image sizes",
               register_writes);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
